// ===== hw/rtl/rcpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Ribbon control point builder package
// Shared widths, codes, state encoding and helper functions.
// ----------------------------------------------------------------------------
package rcpb_pkg;

    localparam int COORD_W = 24;   // Q15.8 coordinate
    localparam int DIFF_W  = 25;   // coordinate difference or sum
    localparam int VEC_W   = 57;   // exact cross product before rescaling
    localparam int SCL_W   = 31;   // rescaled vector component
    localparam int UNIT_W  = 18;   // Q1.16 unit vector component
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int MUL_W   = 32;
    localparam int RAD_W   = 62;   // sum of three squares
    localparam int ROOT_W  = 31;
    localparam int MAG_W   = 31;   // magnitude of a rescaled component
    localparam int PROD_W  = 35;   // Q8.8 times Q1.16
    localparam int CEN_W   = 41;   // Q.24 centre
    localparam int PT_W    = 42;   // Q.24 side point
    localparam int DATA_W  = 9 * COORD_W;

    localparam logic [1:0] CLS_HELIX  = 2'd0;
    localparam logic [1:0] CLS_STRAND = 2'd1;
    localparam logic [1:0] CLS_COIL   = 2'd2;
    localparam logic [1:0] CLS_TURN   = 2'd3;

    localparam logic [ADDR_W-1:0] CFG_HELIX_OFFSET = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_WIDTH_HELIX  = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_WIDTH_STRAND = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_WIDTH_COIL   = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_WIDTH_TURN   = 3'd4;

    localparam logic [CFG_W-1:0] RST_HELIX_OFFSET = 16'd384;
    localparam logic [CFG_W-1:0] RST_WIDTH_HELIX  = 16'd384;
    localparam logic [CFG_W-1:0] RST_WIDTH_STRAND = 16'd384;
    localparam logic [CFG_W-1:0] RST_WIDTH_COIL   = 16'd128;
    localparam logic [CFG_W-1:0] RST_WIDTH_TURN   = 16'd128;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CROSS = 12'b0000_0000_0010,
        ST_FMAX  = 12'b0000_0000_0100,
        ST_SCALE = 12'b0000_0000_1000,
        ST_SQR   = 12'b0000_0001_0000,
        ST_ROOT  = 12'b0000_0010_0000,
        ST_DIVW  = 12'b0000_0100_0000,
        ST_DOT   = 12'b0000_1000_0000,
        ST_FLIP  = 12'b0001_0000_0000,
        ST_PROD  = 12'b0010_0000_0000,
        ST_CEN   = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

    // Request to the root and divide unit.
    typedef struct packed {
        logic start;
        logic div;
    } rd_ctl_t;

    function automatic logic [1:0] idx_next(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    function automatic logic [1:0] idx_prev(input logic [1:0] k);
        return (k == 2'd0) ? 2'd2 : k - 2'd1;
    endfunction

    // Round a Q.24 value to Q.8 and saturate to the coordinate range.
    function automatic logic [COORD_W-1:0] to_q8(input logic signed [PT_W-1:0] x);
        logic signed [PT_W:0]   t;
        logic signed [PT_W-16:0] s;
        t = (PT_W+1)'(x) + (PT_W+1)'(32768);
        s = (PT_W-15)'(t >>> 16);
        if (s > (PT_W-15)'(8388607)) begin
            return 24'h7FFFFF;
        end else if (s < -(PT_W-15)'(8388608)) begin
            return 24'h800000;
        end else begin
            return s[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/ribbon_control_point_builder.sv =====
// ----------------------------------------------------------------------------
// Ribbon control point builder
// Builds the peptide-plane frame of one residue and its three ribbon
// control points with one shared multiplier and one root/divide unit.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tdata: ca0, oxy, ca1 (x,y,z each); tuser: class
//  m_axis   | out       | tdata: center, side1, side2 (x,y,z each)
//  cfg      | in        | write-only registers, index 0..4
//
//  The root/divide unit sets most of the time per residue (one root and
//  three component divides, twice per residue), plus the rescaling of
//  each of the two cross products, one bit per cycle. Reset is
//  synchronous and active low; it restores the control and configuration
//  registers and clears the stored plane vector. A result waits in the
//  output register while the next residue is accepted and worked on.
// ----------------------------------------------------------------------------
module ribbon_control_point_builder import rcpb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // ca0_x, ca0_y, ca0_z, oxy_x, oxy_y, oxy_z, ca1_x, ca1_y, ca1_z
    input  logic [DATA_W-1:0]    s_axis_tdata,
    // structure_class
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // center_x, center_y, center_z, side1_x, side1_y, side1_z,
    // side2_x, side2_y, side2_z
    output logic [DATA_W-1:0]    m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    state_t state_reg, state_next;
    logic [4:0] cnt_reg;
    logic       pass_reg;
    logic [1:0] comp_reg;
    logic [1:0] cls_reg;

    logic [CFG_W-1:0] helix_offset_reg, width_helix_reg, width_strand_reg;
    logic [CFG_W-1:0] width_coil_reg, width_turn_reg;

    logic signed [DIFF_W-1:0] a_reg [3];
    logic signed [DIFF_W-1:0] b_reg [3];
    logic signed [DIFF_W-1:0] sum_reg [3];
    logic signed [VEC_W-1:0]  vec_reg [3];
    logic        [VEC_W-1:0]  mag_reg;
    logic signed [SCL_W-1:0]  c_reg [3];
    logic        [RAD_W-1:0]  n2_reg;
    logic        [ROOT_W-1:0] root_reg;
    logic signed [UNIT_W-1:0] cn_reg [3];
    logic signed [UNIT_W-1:0] dn_reg [3];
    logic signed [UNIT_W-1:0] prev_reg [3];
    logic signed [PROD_W-1:0] dot_reg;
    logic signed [PROD_W-1:0] wd_reg [3];
    logic signed [PROD_W-1:0] off_reg [3];
    logic signed [CEN_W-1:0]  cen_reg [3];
    logic                     m_tvalid_reg;
    logic [DATA_W-1:0]        m_tdata_reg;

    logic s_acc, out_free;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_prod;
    logic [4:0] jm;
    logic [1:0] ki, ka, ia, ib, sq_i, div_idx;
    logic       shrink, grow, scale_done;
    logic [CFG_W-1:0] w_sel;
    rd_ctl_t          rd_ctl;
    logic [RAD_W-1:0] rd_rad;
    logic [MAG_W-1:0] rd_mag;
    logic [ROOT_W-1:0] rd_root, rd_res;
    logic             rd_done;
    logic [VEC_W-1:0] div_abs, res_abs;
    logic signed [UNIT_W-1:0] unit_val;

    function automatic logic [VEC_W-1:0] abs_v(input logic signed [VEC_W-1:0] v);
        return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    endfunction

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // Operation index for issue (cnt) and for write-back in the next cycle.
    assign jm   = cnt_reg - 5'd1;
    assign ki   = (cnt_reg[2:1] == 2'd3) ? 2'd0 : cnt_reg[2:1];
    assign ka   = (jm[2:1] == 2'd3) ? 2'd0 : jm[2:1];
    assign ia   = cnt_reg[0] ? idx_prev(ki) : idx_next(ki);
    assign ib   = cnt_reg[0] ? idx_next(ki) : idx_prev(ki);
    assign sq_i = (cnt_reg[1:0] == 2'd3) ? 2'd0 : cnt_reg[1:0];

    assign shrink     = mag_reg >= (VEC_W'(1) << 30);
    assign grow       = (mag_reg != '0) && (mag_reg < (VEC_W'(1) << 29));
    assign scale_done = !shrink && !grow;

    always_comb begin
        unique case (cls_reg)
            CLS_HELIX:  w_sel = width_helix_reg;
            CLS_STRAND: w_sel = width_strand_reg;
            CLS_COIL:   w_sel = width_coil_reg;
            default:    w_sel = width_turn_reg;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS) begin
            if (pass_reg) begin
                mul_a = MUL_W'(c_reg[ia]);
                mul_b = MUL_W'(a_reg[ib]);
            end else begin
                mul_a = MUL_W'(a_reg[ia]);
                mul_b = MUL_W'(b_reg[ib]);
            end
        end else if (state_reg == ST_SQR) begin
            mul_a = MUL_W'(signed'(vec_reg[sq_i][SCL_W-1:0]));
            mul_b = MUL_W'(signed'(vec_reg[sq_i][SCL_W-1:0]));
        end else if (state_reg == ST_DOT) begin
            mul_a = MUL_W'(prev_reg[sq_i]);
            mul_b = MUL_W'(dn_reg[sq_i]);
        end else if (state_reg == ST_PROD) begin
            if (cnt_reg[0]) begin
                mul_a = MUL_W'(helix_offset_reg);
                mul_b = MUL_W'(cn_reg[ki]);
            end else begin
                mul_a = MUL_W'(w_sel);
                mul_b = MUL_W'(dn_reg[ki]);
            end
        end
    end

    rcpb_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (mul_prod)
    );

    // Root and divide requests.
    assign div_idx      = (state_reg == ST_ROOT || comp_reg == 2'd2) ? 2'd0
                        : comp_reg + 2'd1;
    assign div_abs      = abs_v(vec_reg[div_idx]);
    assign rd_mag       = div_abs[MAG_W-1:0];
    assign rd_root      = (state_reg == ST_ROOT) ? rd_res : root_reg;
    assign rd_rad       = n2_reg + RAD_W'(mul_prod);
    assign rd_ctl.start = (state_reg == ST_SQR && cnt_reg == 5'd3)
                       || (state_reg == ST_ROOT && rd_done)
                       || (state_reg == ST_DIVW && rd_done && comp_reg != 2'd2);
    assign rd_ctl.div   = (state_reg != ST_SQR);

    rcpb_rootdiv u_rootdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rd_ctl),
        .rad      (rd_rad),
        .mag      (rd_mag),
        .root     (rd_root),
        .done_reg (rd_done),
        .res      (rd_res)
    );

    // A zero vector has a zero root and gives a zero unit vector.
    assign res_abs  = VEC_W'(rd_res);
    assign unit_val = (root_reg == '0) ? '0
                    : vec_reg[comp_reg][VEC_W-1] ? -UNIT_W'(res_abs)
                    : UNIT_W'(res_abs);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_acc) state_next = ST_CROSS;
            ST_CROSS: if (cnt_reg == 5'd6) state_next = ST_FMAX;
            ST_FMAX:  state_next = ST_SCALE;
            ST_SCALE: if (scale_done) state_next = ST_SQR;
            ST_SQR:   if (cnt_reg == 5'd3) state_next = ST_ROOT;
            ST_ROOT:  if (rd_done) state_next = ST_DIVW;
            ST_DIVW: begin
                if (rd_done && comp_reg == 2'd2) begin
                    state_next = pass_reg ? ST_DOT : ST_CROSS;
                end
            end
            ST_DOT:   if (cnt_reg == 5'd3) state_next = ST_FLIP;
            ST_FLIP:  state_next = ST_PROD;
            ST_PROD:  if (cnt_reg == 5'd6) state_next = ST_CEN;
            ST_CEN:   state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pass_reg         <= 1'b0;
            comp_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
            helix_offset_reg <= RST_HELIX_OFFSET;
            width_helix_reg  <= RST_WIDTH_HELIX;
            width_strand_reg <= RST_WIDTH_STRAND;
            width_coil_reg   <= RST_WIDTH_COIL;
            width_turn_reg   <= RST_WIDTH_TURN;
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
            if (s_acc) begin
                pass_reg <= 1'b0;
            end else if (state_reg == ST_DIVW && rd_done && comp_reg == 2'd2) begin
                pass_reg <= 1'b1;
            end
            if (state_reg == ST_ROOT && rd_done) begin
                comp_reg <= '0;
            end else if (state_reg == ST_DIVW && rd_done) begin
                comp_reg <= comp_reg + 2'd1;
            end
            if (state_reg == ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    prev_reg[i] <= dn_reg[i];
                end
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_HELIX_OFFSET: helix_offset_reg <= cfg_wdata;
                    CFG_WIDTH_HELIX:  width_helix_reg  <= cfg_wdata;
                    CFG_WIDTH_STRAND: width_strand_reg <= cfg_wdata;
                    CFG_WIDTH_COIL:   width_coil_reg   <= cfg_wdata;
                    CFG_WIDTH_TURN:   width_turn_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cls_reg <= s_axis_tuser;
            for (int i = 0; i < 3; i++) begin
                a_reg[i]   <= DIFF_W'(signed'(s_axis_tdata[COORD_W*(6+i) +: COORD_W]))
                            - DIFF_W'(signed'(s_axis_tdata[COORD_W*i +: COORD_W]));
                b_reg[i]   <= DIFF_W'(signed'(s_axis_tdata[COORD_W*(3+i) +: COORD_W]))
                            - DIFF_W'(signed'(s_axis_tdata[COORD_W*i +: COORD_W]));
                sum_reg[i] <= DIFF_W'(signed'(s_axis_tdata[COORD_W*(6+i) +: COORD_W]))
                            + DIFF_W'(signed'(s_axis_tdata[COORD_W*i +: COORD_W]));
            end
        end

        if (state_reg == ST_CROSS && cnt_reg != 5'd0) begin
            if (jm[0]) begin
                vec_reg[ka] <= vec_reg[ka] - VEC_W'(mul_prod);
            end else begin
                vec_reg[ka] <= VEC_W'(mul_prod);
            end
        end

        if (state_reg == ST_FMAX) begin
            mag_reg <= abs_v(vec_reg[0]);
            if (abs_v(vec_reg[1]) > abs_v(vec_reg[0])
                && abs_v(vec_reg[1]) >= abs_v(vec_reg[2])) begin
                mag_reg <= abs_v(vec_reg[1]);
            end else if (abs_v(vec_reg[2]) > abs_v(vec_reg[0])
                && abs_v(vec_reg[2]) > abs_v(vec_reg[1])) begin
                mag_reg <= abs_v(vec_reg[2]);
            end
        end

        // Rescale one bit per cycle: the shift count follows the largest
        // magnitude, and right shifts round toward minus infinity.
        if (state_reg == ST_SCALE) begin
            if (shrink) begin
                mag_reg <= mag_reg >> 1;
                for (int i = 0; i < 3; i++) vec_reg[i] <= vec_reg[i] >>> 1;
            end else if (grow) begin
                mag_reg <= mag_reg << 1;
                for (int i = 0; i < 3; i++) vec_reg[i] <= vec_reg[i] <<< 1;
            end else if (!pass_reg) begin
                for (int i = 0; i < 3; i++) c_reg[i] <= SCL_W'(vec_reg[i]);
            end
        end

        if (state_reg == ST_SQR && cnt_reg != 5'd0) begin
            n2_reg <= (cnt_reg == 5'd1) ? RAD_W'(mul_prod) : rd_rad;
        end

        if (state_reg == ST_ROOT && rd_done) begin
            root_reg <= rd_res;
        end

        if (state_reg == ST_DIVW && rd_done) begin
            if (pass_reg) begin
                dn_reg[comp_reg] <= unit_val;
            end else begin
                cn_reg[comp_reg] <= unit_val;
            end
        end

        if (state_reg == ST_DOT && cnt_reg != 5'd0) begin
            dot_reg <= (cnt_reg == 5'd1) ? PROD_W'(mul_prod) : dot_reg + PROD_W'(mul_prod);
        end

        if (state_reg == ST_FLIP && cls_reg != CLS_HELIX && dot_reg[PROD_W-1]) begin
            for (int i = 0; i < 3; i++) dn_reg[i] <= -dn_reg[i];
        end

        if (state_reg == ST_PROD && cnt_reg != 5'd0) begin
            if (jm[0]) begin
                off_reg[ka] <= PROD_W'(mul_prod);
            end else begin
                wd_reg[ka] <= PROD_W'(mul_prod);
            end
        end

        if (state_reg == ST_CEN) begin
            for (int i = 0; i < 3; i++) begin
                cen_reg[i] <= (CEN_W'(sum_reg[i]) <<< 15)
                            + ((cls_reg == CLS_HELIX) ? CEN_W'(off_reg[i]) : '0);
            end
        end

        if (state_reg == ST_FIN && out_free) begin
            for (int i = 0; i < 3; i++) begin
                m_tdata_reg[COORD_W*i +: COORD_W] <= to_q8(PT_W'(cen_reg[i]));
                m_tdata_reg[COORD_W*(3+i) +: COORD_W]
                    <= to_q8(PT_W'(cen_reg[i]) + PT_W'(wd_reg[i]));
                m_tdata_reg[COORD_W*(6+i) +: COORD_W]
                    <= to_q8(PT_W'(cen_reg[i]) - PT_W'(wd_reg[i]));
            end
        end
    end

endmodule

// ===== hw/rtl/rcpb_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module rcpb_mul import rcpb_pkg::*; (
    input  logic                        aclk,
    input  logic signed [MUL_W-1:0]     op_a,
    input  logic signed [MUL_W-1:0]     op_b,
    output logic signed [2*MUL_W-1:0]   prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

// ===== hw/rtl/rcpb_rootdiv.sv =====
// ----------------------------------------------------------------------------
// Root and divide unit
// Bit-serial integer square root (one result bit per cycle) and restoring
// division for the rounded unit vector component (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module rcpb_rootdiv import rcpb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  rd_ctl_t             ctl,
    input  logic [RAD_W-1:0]    rad,
    input  logic [MAG_W-1:0]    mag,
    input  logic [ROOT_W-1:0]   root,
    output logic                done_reg,
    output logic [ROOT_W-1:0]   res
);

    localparam int QB = 18;

    logic              busy_reg;
    logic              div_reg;
    logic [4:0]        cnt_reg;
    logic [RAD_W-1:0]  rem_reg;
    logic [RAD_W:0]    r_reg;
    logic [RAD_W:0]    bit_reg;
    logic [31:0]       drem_reg;
    logic [QB-1:0]     dlo_reg;
    logic [QB-1:0]     q_reg;
    logic [31:0]       dvs_reg;

    logic [RAD_W:0]    trial;
    logic              sq_ge;
    logic [32:0]       dtrial;
    logic              d_ge;
    logic [47:0]       num;

    assign trial  = r_reg + bit_reg;
    assign sq_ge  = {1'b0, rem_reg} >= trial;
    assign dtrial = {drem_reg, dlo_reg[QB-1]};
    assign d_ge   = dtrial >= {1'b0, dvs_reg};
    assign num    = 48'({mag, 17'b0}) + 48'(root);
    assign res    = div_reg ? ROOT_W'(q_reg) : r_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            div_reg  <= ctl.div;
            rem_reg  <= rad;
            r_reg    <= '0;
            bit_reg  <= (RAD_W+1)'(1) << (RAD_W - 2 + 2);
            // The quotient is at most 2^16, so the upper numerator bits are
            // already below the divisor.
            drem_reg <= 32'(num[47:QB]);
            dlo_reg  <= num[QB-1:0];
            q_reg    <= '0;
            dvs_reg  <= {root, 1'b0};
            cnt_reg  <= ctl.div ? 5'(QB - 1) : 5'(ROOT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (div_reg) begin
                drem_reg <= d_ge ? 32'(dtrial - {1'b0, dvs_reg}) : dtrial[31:0];
                dlo_reg  <= {dlo_reg[QB-2:0], 1'b0};
                q_reg    <= {q_reg[QB-2:0], d_ge};
            end else begin
                if (sq_ge) begin
                    rem_reg <= rem_reg - trial[RAD_W-1:0];
                    r_reg   <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg   <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

endmodule

// ===== hw/rtl/rcpb_checker.sv =====
// ----------------------------------------------------------------------------
// Ribbon control point builder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rcpb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [215:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // Once a residue is accepted, the block stays busy and takes no other.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a residue is in progress");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

endmodule

bind ribbon_control_point_builder rcpb_checker u_rcpb_checker (.*);
